FILE: rtl/core/rotate_shift_bit_unit_core_defines.svh
// assertion macros used by the core module rotate_shift_bit_unit_core
`ifndef ROTATE_SHIFT_BIT_UNIT_CORE_DEFINES_SVH
`define ROTATE_SHIFT_BIT_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define RSBU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rsbu check failed");

`define RSBU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsbu implication failed");

`define RSBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsbu sequence failed");

`else

`define RSBU_ASSERT(lbl, clk, rst_n, prop)
`define RSBU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RSBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/rsbu_pkg.sv
package rsbu_pkg;

    typedef struct packed {
        logic [7:0] opcode;
        logic [1:0] prefix_kind;
        logic       indexed;
        logic [7:0] operand;
        logic [7:0] accum_in;
        logic [7:0] flags_in;
    } rsbu_cmd_t;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] accum_out;
        logic [7:0] flags_out;
        logic       writes_back;
        logic [4:0] tstates;
        logic       illegal;
    } rsbu_rsp_t;

    // prefix kinds
    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_CB   = 2'd1;
    localparam logic [1:0] PFX_ED   = 2'd2;

    // unprefixed accumulator rotates
    localparam logic [7:0] OP_RLCA = 8'h07;
    localparam logic [7:0] OP_RRCA = 8'h0F;
    localparam logic [7:0] OP_RLA  = 8'h17;
    localparam logic [7:0] OP_RRA  = 8'h1F;

    // ed nibble rotates, each with its alias
    localparam logic [7:0] OP_RRD  = 8'h67;
    localparam logic [7:0] OP_RRD2 = 8'h77;
    localparam logic [7:0] OP_RLD  = 8'h6F;
    localparam logic [7:0] OP_RLD2 = 8'h7F;

    // cb groups
    localparam logic [1:0] GRP_SHIFT = 2'd0;
    localparam logic [1:0] GRP_BIT   = 2'd1;
    localparam logic [1:0] GRP_RES   = 2'd2;
    localparam logic [1:0] GRP_SET   = 2'd3;

    // cb shift kinds
    localparam logic [2:0] SHF_RLC = 3'd0;
    localparam logic [2:0] SHF_RRC = 3'd1;
    localparam logic [2:0] SHF_RL  = 3'd2;
    localparam logic [2:0] SHF_RR  = 3'd3;
    localparam logic [2:0] SHF_SLA = 3'd4;
    localparam logic [2:0] SHF_SRA = 3'd5;
    localparam logic [2:0] SHF_SLL = 3'd6;
    localparam logic [2:0] SHF_SRL = 3'd7;

    // cb register field codes
    localparam logic [2:0] REG_HL_MEM = 3'd6;
    localparam logic [2:0] REG_ACC    = 3'd7;

    localparam logic [7:0] FL_KEEP_ROT = 8'hC4;  // s z p
    localparam logic [7:0] FL_MASK_53  = 8'h28;
    localparam logic [7:0] FL_MASK_S53 = 8'hA8;

    localparam logic [4:0] TS_NONE     = 5'd0;
    localparam logic [4:0] TS_REG      = 5'd4;
    localparam logic [4:0] TS_BIT_MEM  = 5'd8;
    localparam logic [4:0] TS_MEM      = 5'd11;
    localparam logic [4:0] TS_NIBBLE   = 5'd14;
    localparam logic [4:0] TS_BIT_IDX  = 5'd16;
    localparam logic [4:0] TS_IDX      = 5'd19;

    // sign, zero, 5, 3 and even parity of a byte
    function automatic logic [7:0] szp_flags(input logic [7:0] v);
        logic [7:0] f;
        f    = v & FL_MASK_S53;
        f[6] = (v == 8'h00);
        f[2] = ~^v;
        return f;
    endfunction

endpackage

FILE: rtl/core/rsbu_alu.sv
module rsbu_alu
    import rsbu_pkg::*;
(
    input  rsbu_cmd_t cmd,
    output rsbu_rsp_t rsp
);

    logic [7:0] v;
    logic [7:0] a;
    logic [7:0] f;
    logic       cin;
    logic [1:0] grp;
    logic [2:0] bitno;
    logic [2:0] regno;
    logic [7:0] mask;
    logic [7:0] acc_rot;
    logic       acc_co;
    logic       acc_ok;
    logic [7:0] shf_res;
    logic       shf_co;
    logic       bit_z;
    logic       is_rrd;
    logic       is_rld;

    assign v     = cmd.operand;
    assign a     = cmd.accum_in;
    assign f     = cmd.flags_in;
    assign cin   = cmd.flags_in[0];
    assign grp   = cmd.opcode[7:6];
    assign bitno = cmd.opcode[5:3];
    assign regno = cmd.opcode[2:0];
    assign mask  = 8'h01 << bitno;
    assign bit_z = ~v[bitno];

    assign is_rrd = (cmd.opcode == OP_RRD) || (cmd.opcode == OP_RRD2);
    assign is_rld = (cmd.opcode == OP_RLD) || (cmd.opcode == OP_RLD2);

    // accumulator rotates
    always_comb
    begin
        acc_rot = a;
        acc_co  = 1'b0;
        acc_ok  = 1'b1;
        unique case (cmd.opcode)
            OP_RLCA:
            begin
                acc_rot = {a[6:0], a[7]};
                acc_co  = a[7];
            end
            OP_RRCA:
            begin
                acc_rot = {a[0], a[7:1]};
                acc_co  = a[0];
            end
            OP_RLA:
            begin
                acc_rot = {a[6:0], cin};
                acc_co  = a[7];
            end
            OP_RRA:
            begin
                acc_rot = {cin, a[7:1]};
                acc_co  = a[0];
            end
            default:
            begin
                acc_ok = 1'b0;
            end
        endcase
    end

    // cb rotates and shifts
    always_comb
    begin
        unique case (bitno)
            SHF_RLC: begin shf_res = {v[6:0], v[7]}; shf_co = v[7]; end
            SHF_RRC: begin shf_res = {v[0], v[7:1]}; shf_co = v[0]; end
            SHF_RL:  begin shf_res = {v[6:0], cin};  shf_co = v[7]; end
            SHF_RR:  begin shf_res = {cin, v[7:1]};  shf_co = v[0]; end
            SHF_SLA: begin shf_res = {v[6:0], 1'b0}; shf_co = v[7]; end
            SHF_SRA: begin shf_res = {v[7], v[7:1]}; shf_co = v[0]; end
            SHF_SLL: begin shf_res = {v[6:0], 1'b1}; shf_co = v[7]; end
            SHF_SRL: begin shf_res = {1'b0, v[7:1]}; shf_co = v[0]; end
            default: begin shf_res = v;              shf_co = 1'b0; end
        endcase
    end

    always_comb
    begin
        rsp.result      = v;
        rsp.accum_out   = a;
        rsp.flags_out   = f;
        rsp.writes_back = 1'b0;
        rsp.tstates     = TS_NONE;
        rsp.illegal     = 1'b0;
        unique case (cmd.prefix_kind)
            PFX_NONE:
            begin
                if (acc_ok)
                begin
                    rsp.result    = acc_rot;
                    rsp.accum_out = acc_rot;
                    rsp.flags_out = (f & FL_KEEP_ROT) | (acc_rot & FL_MASK_53)
                                    | {7'd0, acc_co};
                    rsp.tstates   = TS_REG;
                end
                else
                begin
                    rsp.illegal = 1'b1;
                end
            end
            PFX_CB:
            begin
                unique case (grp)
                    GRP_SHIFT:
                    begin
                        rsp.result      = shf_res;
                        rsp.flags_out   = szp_flags(shf_res) | {7'd0, shf_co};
                        rsp.writes_back = 1'b1;
                    end
                    GRP_BIT:
                    begin
                        rsp.flags_out = {(bitno == 3'd7) & v[7], bit_z, v[5], 1'b1,
                                         v[3], bit_z, 1'b0, cin};
                    end
                    GRP_RES:
                    begin
                        rsp.result      = v & ~mask;
                        rsp.writes_back = 1'b1;
                    end
                    default:
                    begin
                        rsp.result      = v | mask;
                        rsp.writes_back = 1'b1;
                    end
                endcase
                if (grp == GRP_BIT)
                    rsp.tstates = cmd.indexed ? TS_BIT_IDX :
                                  (regno == REG_HL_MEM) ? TS_BIT_MEM : TS_REG;
                else
                    rsp.tstates = cmd.indexed ? TS_IDX :
                                  (regno == REG_HL_MEM) ? TS_MEM : TS_REG;
                // register field 7 without index prefix targets the accumulator
                if (rsp.writes_back && regno == REG_ACC && !cmd.indexed)
                    rsp.accum_out = rsp.result;
            end
            PFX_ED:
            begin
                if (is_rrd || is_rld)
                begin
                    if (is_rrd)
                    begin
                        rsp.result    = {a[3:0], v[7:4]};
                        rsp.accum_out = {a[7:4], v[3:0]};
                    end
                    else
                    begin
                        rsp.result    = {v[3:0], a[3:0]};
                        rsp.accum_out = {a[7:4], v[7:4]};
                    end
                    rsp.flags_out   = szp_flags(rsp.accum_out) | {7'd0, cin};
                    rsp.writes_back = 1'b1;
                    rsp.tstates     = TS_NIBBLE;
                end
                else
                begin
                    rsp.illegal = 1'b1;
                end
            end
            default:
            begin
                rsp.illegal = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/rotate_shift_bit_unit_core.sv
// z80 rotate, shift and bit unit
//
// command channel: cmd is taken at a rising edge where start is high and busy
// is low. busy is high only during reset and until a clock edge with rst_n high
// clears it; from then on a command may be issued in every cycle.
// result channel: rsp is valid for exactly one cycle, marked by done, and is
// taken at the edge that ends that cycle. the receiver cannot hold it off.
// path: the command is captured in the input register, then passes through
// the combinational execute logic into the result register, marked by done.
// throughput: one command per cycle, sustained, set by the single pass through
// the execute logic between the two register stages.
// reset (rst_n low, asynchronous) clears both valid bits and sets busy; any
// command in flight is dropped. the unit keeps no state between commands.
`include "rotate_shift_bit_unit_core_defines.svh"

module rotate_shift_bit_unit_core
    import rsbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  rsbu_cmd_t cmd,
    output logic      done,
    output rsbu_rsp_t rsp
);

    logic      busy_reg;
    logic      cmd_valid_reg;
    logic      cmd_valid_next;
    rsbu_cmd_t cmd_reg;
    logic      done_reg;
    rsbu_rsp_t rsp_reg;
    rsbu_rsp_t rsp_next;

    assign cmd_valid_next = start && !busy_reg;

    rsbu_alu u_alu (
        .cmd (cmd_reg),
        .rsp (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            cmd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= 1'b0;
            cmd_valid_reg <= cmd_valid_next;
            done_reg      <= cmd_valid_reg;
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_valid_next)
            cmd_reg <= cmd;
        if (cmd_valid_reg)
            rsp_reg <= rsp_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `RSBU_ASSERT_NEXT(a_transfer_reaches_output, clk, rst_n,
        cmd_valid_reg, done)
    `RSBU_ASSERT_IMP(a_illegal_is_inert, clk, rst_n,
        done && rsp.illegal, !rsp.writes_back && rsp.tstates == TS_NONE)
    `RSBU_ASSERT_IMP(a_legal_takes_time, clk, rst_n,
        done && !rsp.illegal, rsp.tstates != TS_NONE)
    `RSBU_ASSERT_IMP(a_bit_no_writeback, clk, rst_n,
        done && (rsp.tstates == TS_BIT_MEM || rsp.tstates == TS_BIT_IDX),
        !rsp.writes_back)
    `RSBU_ASSERT(a_done_needs_issue, clk, rst_n,
        !done || $past(cmd_valid_reg))

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import rsbu_pkg::*;

    localparam int N_RANDOM = 2000;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 4;

    // codes the package does not name
    localparam logic [1:0] PFX_RSVD = 2'd3;
    localparam logic [7:0] OP_NOP = 8'h00;
    localparam logic [7:0] OP_ED_NEG = 8'h44;
    localparam logic [2:0] REG_B = 3'd0;
    localparam logic [2:0] REG_E = 3'd3;
    localparam logic [2:0] BIT_SIGN = 3'd7;

    localparam logic [7:0] FLAG_S = 8'h80;
    localparam logic [7:0] FLAG_Z = 8'h40;
    localparam logic [7:0] FLAG_H = 8'h10;
    localparam logic [7:0] FLAG_P = 8'h04;

    typedef struct {
        rsbu_cmd_t c;
        bit        typed;
        rsbu_rsp_t r;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    rsbu_cmd_t cmd;
    logic      done;
    rsbu_rsp_t rsp;

    rsbu_rsp_t pending_results[$];
    dir_row_t  dir_rows[$];
    int        errors = 0;
    int        results_checked = 0;
    int        idle_cycles = 0;
    int        n_rot = 0, n_cb = 0, n_ed = 0, n_bad = 0;

    rotate_shift_bit_unit_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sign, zero, 5, 3 and even parity of a byte
    function automatic logic [7:0] sz53p(input logic [7:0] v);
        logic [7:0] f;
        f = v & FL_MASK_S53;
        if (v == 8'h00)
            f = f | FLAG_Z;
        if (~(^v))
            f = f | FLAG_P;
        return f;
    endfunction

    function automatic rsbu_rsp_t z80_bit_group_exec(input rsbu_cmd_t c);
        rsbu_rsp_t  r;
        logic [7:0] v, a, f, mask, res;
        logic [1:0] grp;
        logic [2:0] kind, sel;
        logic       cin, co, is_mem;
        v = c.operand;
        a = c.accum_in;
        f = c.flags_in;
        cin = f[0];
        co = 1'b0;
        res = v;
        grp = c.opcode[7:6];
        kind = c.opcode[5:3];
        sel = c.opcode[2:0];
        mask = 8'h01 << kind;
        is_mem = (sel == REG_HL_MEM);
        r.result = v;
        r.accum_out = a;
        r.flags_out = f;
        r.writes_back = 1'b0;
        r.tstates = TS_NONE;
        r.illegal = 1'b0;
        case (c.prefix_kind)
            PFX_NONE:
            begin
                r.tstates = TS_REG;
                case (c.opcode)
                    OP_RLCA: begin res = {a[6:0], a[7]}; co = a[7]; end
                    OP_RRCA: begin res = {a[0], a[7:1]}; co = a[0]; end
                    OP_RLA:  begin res = {a[6:0], cin};  co = a[7]; end
                    OP_RRA:  begin res = {cin, a[7:1]};  co = a[0]; end
                    default:
                    begin
                        r.illegal = 1'b1;
                        r.tstates = TS_NONE;
                    end
                endcase
                if (!r.illegal)
                begin
                    r.result = res;
                    r.accum_out = res;
                    r.flags_out = (f & FL_KEEP_ROT) | (res & FL_MASK_53) | {7'b0, co};
                end
            end
            PFX_CB:
            begin
                case (grp)
                    GRP_SHIFT:
                    begin
                        case (kind)
                            SHF_RLC: begin res = {v[6:0], v[7]};  co = v[7]; end
                            SHF_RRC: begin res = {v[0], v[7:1]};  co = v[0]; end
                            SHF_RL:  begin res = {v[6:0], cin};   co = v[7]; end
                            SHF_RR:  begin res = {cin, v[7:1]};   co = v[0]; end
                            SHF_SLA: begin res = {v[6:0], 1'b0};  co = v[7]; end
                            SHF_SRA: begin res = {v[7], v[7:1]};  co = v[0]; end
                            SHF_SLL: begin res = {v[6:0], 1'b1};  co = v[7]; end
                            default: begin res = {1'b0, v[7:1]};  co = v[0]; end
                        endcase
                        r.result = res;
                        r.flags_out = sz53p(res) | {7'b0, co};
                        r.writes_back = 1'b1;
                        r.tstates = c.indexed ? TS_IDX : (is_mem ? TS_MEM : TS_REG);
                    end
                    GRP_BIT:
                    begin
                        r.flags_out = (v & FL_MASK_53) | FLAG_H | {7'b0, cin};
                        if ((v & mask) == 8'h00)
                            r.flags_out = r.flags_out | FLAG_Z | FLAG_P;
                        if (kind == BIT_SIGN && v[7])
                            r.flags_out = r.flags_out | FLAG_S;
                        r.tstates = c.indexed ? TS_BIT_IDX : (is_mem ? TS_BIT_MEM : TS_REG);
                    end
                    default:
                    begin
                        r.result = (grp == GRP_RES) ? (v & ~mask) : (v | mask);
                        r.writes_back = 1'b1;
                        r.tstates = c.indexed ? TS_IDX : (is_mem ? TS_MEM : TS_REG);
                    end
                endcase
                // unindexed target field 7 is the accumulator itself
                if (r.writes_back && sel == REG_ACC && !c.indexed)
                    r.accum_out = r.result;
            end
            PFX_ED:
            begin
                if (c.opcode == OP_RRD || c.opcode == OP_RRD2)
                begin
                    r.result = {a[3:0], v[7:4]};
                    r.accum_out = {a[7:4], v[3:0]};
                end
                else if (c.opcode == OP_RLD || c.opcode == OP_RLD2)
                begin
                    r.result = {v[3:0], a[3:0]};
                    r.accum_out = {a[7:4], v[7:4]};
                end
                else
                    r.illegal = 1'b1;
                if (!r.illegal)
                begin
                    r.flags_out = sz53p(r.accum_out) | {7'b0, cin};
                    r.writes_back = 1'b1;
                    r.tstates = TS_NIBBLE;
                end
            end
            default:
                r.illegal = 1'b1;
        endcase
        return r;
    endfunction

    function automatic rsbu_cmd_t mk_cmd(input logic [7:0] op, input logic [1:0] pk,
                                         input logic idx, input logic [7:0] v,
                                         input logic [7:0] a, input logic [7:0] f);
        rsbu_cmd_t c;
        c.opcode = op;
        c.prefix_kind = pk;
        c.indexed = idx;
        c.operand = v;
        c.accum_in = a;
        c.flags_in = f;
        return c;
    endfunction

    task automatic row_pred(input logic [7:0] op, input logic [1:0] pk, input logic idx,
                            input logic [7:0] v, input logic [7:0] a, input logic [7:0] f);
        dir_row_t row;
        row.c = mk_cmd(op, pk, idx, v, a, f);
        row.typed = 1'b0;
        row.r = '0;
        dir_rows.push_back(row);
    endtask

    task automatic row_typed(input logic [7:0] op, input logic [1:0] pk, input logic idx,
                             input logic [7:0] v, input logic [7:0] a, input logic [7:0] f,
                             input logic [7:0] res, input logic [7:0] acc,
                             input logic [7:0] fl, input logic wb, input logic [4:0] ts,
                             input logic ill);
        dir_row_t row;
        row.c = mk_cmd(op, pk, idx, v, a, f);
        row.typed = 1'b1;
        row.r.result = res;
        row.r.accum_out = acc;
        row.r.flags_out = fl;
        row.r.writes_back = wb;
        row.r.tstates = ts;
        row.r.illegal = ill;
        dir_rows.push_back(row);
    endtask

    function automatic rsbu_cmd_t rand_cmd();
        rsbu_cmd_t c;
        int        pick;
        c.opcode = 8'($urandom);
        c.prefix_kind = 2'($urandom);
        c.indexed = 1'($urandom);
        c.operand = 8'($urandom);
        c.accum_in = 8'($urandom);
        c.flags_in = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            c.prefix_kind = PFX_NONE;
            case ($urandom_range(0, 3))
                0: c.opcode = OP_RLCA;
                1: c.opcode = OP_RRCA;
                2: c.opcode = OP_RLA;
                default: c.opcode = OP_RRA;
            endcase
        end
        else if (pick < 20)
            c.prefix_kind = PFX_NONE;
        else if (pick < 70)
            c.prefix_kind = PFX_CB;
        else if (pick < 85)
        begin
            c.prefix_kind = PFX_ED;
            case ($urandom_range(0, 3))
                0: c.opcode = OP_RRD;
                1: c.opcode = OP_RRD2;
                2: c.opcode = OP_RLD;
                default: c.opcode = OP_RLD2;
            endcase
        end
        else if (pick < 93)
            c.prefix_kind = PFX_ED;
        else
            c.prefix_kind = PFX_RSVD;
        // lean on the byte extremes now and then
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0: c.operand = 8'h00;
                1: c.operand = 8'hFF;
                2: c.operand = 8'h80;
                default: c.operand = 8'h01;
            endcase
        end
        return c;
    endfunction

    // one transfer on the command side; returns in the step of the accepting edge
    task automatic send(input rsbu_cmd_t c, input bit typed, input rsbu_rsp_t r);
        rsbu_rsp_t want;
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        want = typed ? r : z80_bit_group_exec(c);
        pending_results.push_back(want);
        if (want.illegal)
            n_bad++;
        else if (c.prefix_kind == PFX_NONE)
            n_rot++;
        else if (c.prefix_kind == PFX_CB)
            n_cb++;
        else
            n_ed++;
    endtask

    task automatic pause(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        rsbu_rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = pending_results.pop_front();
                    cmp_field("result", rsp.result, want.result);
                    cmp_field("accum_out", rsp.accum_out, want.accum_out);
                    cmp_field("flags_out", rsp.flags_out, want.flags_out);
                    cmp_field("writes_back", {7'b0, rsp.writes_back}, {7'b0, want.writes_back});
                    cmp_field("tstates", {3'b0, rsp.tstates}, {3'b0, want.tstates});
                    cmp_field("illegal", {7'b0, rsp.illegal}, {7'b0, want.illegal});
                    results_checked++;
                end
            end
        end
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d cycles with no transfer", IDLE_LIMIT);
            $display("FAIL rotate_shift_bit_unit_core");
            $finish;
        end
    end

    initial
    begin
        int  n_sent;
        int  burst;
        int  k;
        int  bursts;
        bit  drained_mid;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        n_sent = 0;
        bursts = 0;
        drained_mid = 1'b0;

        // accumulator rotates, carry in and out, flags kept
        row_typed(OP_RLCA, PFX_NONE, 1'b0, 8'h00, 8'h80, 8'h00,
                  8'h01, 8'h01, 8'h01, 1'b0, TS_REG, 1'b0);
        row_typed(OP_RRCA, PFX_NONE, 1'b0, 8'hFF, 8'h01, 8'hFF,
                  8'h80, 8'h80, 8'hC5, 1'b0, TS_REG, 1'b0);
        row_pred(OP_RLA, PFX_NONE, 1'b1, 8'hFF, 8'hFF, 8'h00);
        row_typed(OP_RRA, PFX_NONE, 1'b0, 8'h00, 8'h00, 8'h01,
                  8'h80, 8'h80, 8'h00, 1'b0, TS_REG, 1'b0);
        // unhandled opcodes pass everything through
        row_typed(OP_NOP, PFX_NONE, 1'b0, 8'h5A, 8'h3C, 8'h96,
                  8'h5A, 8'h3C, 8'h96, 1'b0, TS_NONE, 1'b1);
        row_typed(OP_RLCA, PFX_RSVD, 1'b1, 8'hA5, 8'hC3, 8'h69,
                  8'hA5, 8'hC3, 8'h69, 1'b0, TS_NONE, 1'b1);
        row_typed(OP_ED_NEG, PFX_ED, 1'b0, 8'h5A, 8'h3C, 8'hFF,
                  8'h5A, 8'h3C, 8'hFF, 1'b0, TS_NONE, 1'b1);
        // every cb shift kind, register, (hl), indexed and accumulator targets
        row_pred({GRP_SHIFT, SHF_RLC, REG_B}, PFX_CB, 1'b0, 8'h80, 8'h00, 8'h00);
        row_pred({GRP_SHIFT, SHF_RRC, REG_HL_MEM}, PFX_CB, 1'b0, 8'h01, 8'hFF, 8'hFF);
        row_pred({GRP_SHIFT, SHF_RL, REG_ACC}, PFX_CB, 1'b0, 8'hFF, 8'hFF, 8'h01);
        row_pred({GRP_SHIFT, SHF_RR, REG_ACC}, PFX_CB, 1'b1, 8'h00, 8'h00, 8'h01);
        row_pred({GRP_SHIFT, SHF_SLA, REG_E}, PFX_CB, 1'b0, 8'hC0, 8'h42, 8'h00);
        row_pred({GRP_SHIFT, SHF_SRA, REG_HL_MEM}, PFX_CB, 1'b1, 8'h80, 8'h00, 8'hFF);
        row_pred({GRP_SHIFT, SHF_SLL, REG_ACC}, PFX_CB, 1'b0, 8'h00, 8'h55, 8'h00);
        row_typed({GRP_SHIFT, SHF_SRL, REG_B}, PFX_CB, 1'b0, 8'h01, 8'h77, 8'h00,
                  8'h00, 8'h77, 8'h45, 1'b1, TS_REG, 1'b0);
        // bit tests, sign only for bit 7
        row_typed({GRP_BIT, 3'd0, REG_HL_MEM}, PFX_CB, 1'b0, 8'h00, 8'h11, 8'h01,
                  8'h00, 8'h11, 8'h55, 1'b0, TS_BIT_MEM, 1'b0);
        row_pred({GRP_BIT, BIT_SIGN, REG_ACC}, PFX_CB, 1'b1, 8'h80, 8'hFF, 8'h00);
        row_pred({GRP_BIT, BIT_SIGN, REG_B}, PFX_CB, 1'b0, 8'h7F, 8'h00, 8'hFF);
        // res and set, flags untouched
        row_typed({GRP_RES, BIT_SIGN, REG_ACC}, PFX_CB, 1'b0, 8'hFF, 8'h12, 8'hA5,
                  8'h7F, 8'h7F, 8'hA5, 1'b1, TS_REG, 1'b0);
        row_pred({GRP_SET, 3'd0, REG_HL_MEM}, PFX_CB, 1'b1, 8'h00, 8'h00, 8'h00);
        row_pred({GRP_SET, 3'd4, REG_ACC}, PFX_CB, 1'b1, 8'h00, 8'h99, 8'h3C);
        // nibble rotates and their aliases
        row_pred(OP_RRD, PFX_ED, 1'b0, 8'hFF, 8'h00, 8'h01);
        row_pred(OP_RRD2, PFX_ED, 1'b1, 8'h12, 8'h34, 8'hFE);
        row_pred(OP_RLD, PFX_ED, 1'b0, 8'h00, 8'hFF, 8'h00);
        row_pred(OP_RLD2, PFX_ED, 1'b1, 8'hAB, 8'hCD, 8'hFF);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
            pause($urandom_range(0, 2));
        end
        wait_drained();

        while (n_sent < N_RANDOM)
        begin
            bursts++;
            // every eighth burst is a long gap-free stretch
            burst = (bursts % 8 == 0) ? 150 : $urandom_range(1, 24);
            for (k = 0; k < burst && n_sent < N_RANDOM; k++)
            begin
                send(rand_cmd(), 1'b0, '0);
                n_sent++;
            end
            if (!drained_mid && n_sent >= N_RANDOM / 2)
            begin
                wait_drained();
                drained_mid = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d directed and %0d random transfers, %0d results checked",
                 dir_rows.size(), n_sent, results_checked);
        $display("acc rotates %0d, cb ops %0d, ed nibble ops %0d, unhandled %0d, errors %0d",
                 n_rot, n_cb, n_ed, n_bad, errors);
        if (errors == 0)
            $display("PASS rotate_shift_bit_unit_core");
        else
            $display("FAIL rotate_shift_bit_unit_core");
        $finish;
    end

endmodule
